FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the monitor RTL; they compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");
// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`ASSERT_PROP(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: rtl/core/omtw_pkg.sv
// Types and constants shared by the over-temperature monitor modules.
`timescale 1ns / 1ps

package omtw_pkg;

	// Temperature in signed 1/16 degree C units.
	typedef logic signed [11:0] temp_t;
	typedef logic [15:0] ticks_t;

	// Sensor code that means the conversion gave no response.
	localparam temp_t NO_READING = -12'sd2032;

	// Configuration register indexes.
	localparam logic [2:0] CFG_WARN_LEVEL        = 3'd0;
	localparam logic [2:0] CFG_TRIP_LEVEL        = 3'd1;
	localparam logic [2:0] CFG_CONVERSION_TICKS  = 3'd2;
	localparam logic [2:0] CFG_TRIP_WINDOW_TICKS = 3'd3;
	localparam logic [2:0] CFG_SENSOR_PRESENT    = 3'd4;

	// Reset values of the configuration registers.
	localparam temp_t  WARN_LEVEL_RST        = 12'sd960;
	localparam temp_t  TRIP_LEVEL_RST        = 12'sd1280;
	localparam ticks_t CONVERSION_TICKS_RST  = 16'd750;
	localparam ticks_t TRIP_WINDOW_TICKS_RST = 16'd10000;

	// Current configuration, from the register file to the tick logic.
	typedef struct packed {
		temp_t  warn_level;
		temp_t  trip_level;
		ticks_t conversion_ticks;
		ticks_t trip_window_ticks;
		logic   sensor_present;
	} cfg_t;

	// One result word.
	typedef struct packed {
		logic  request_conversion;
		logic  no_response;
		temp_t temperature;
		logic  warning;
		logic  error;
		logic  display_refresh;
	} result_t;

endpackage

FILE: rtl/core/overtemp_monitor_with_trip_window.sv
// Top level of the over-temperature monitor with trip window.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall  reading
//   out       source     out_valid / out_stall request_conversion .. display_refresh
//   cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One tick word is taken every cycle while in_stall is low; each tick waits in the input
// register until the result register can load, and its result word is then loaded there.
// The throughput is set by the combinational state update between the two registers.
// A stalled result holds in the result register while the input register still
// takes a word; in_stall rises only when both registers are full and out is stalled.
// Reset clears the valid flags and the tick state and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module overtemp_monitor_with_trip_window #(
	parameter int unsigned RETRY_LIMIT = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  omtw_pkg::temp_t reading,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            request_conversion,
	output logic            no_response,
	output omtw_pkg::temp_t temperature,
	output logic            warning,
	output logic            error,
	output logic            display_refresh,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [15:0]     cfg_data
);
	import omtw_pkg::*;

	cfg_t    cfg;
	logic    valid_s1;
	temp_t   reading_s1;
	logic    out_free;
	logic    adv_s1;
	logic    in_take;
	result_t res_next;
	logic    out_valid_q;
	result_t res_q;

	// Configuration is always accepted.
	assign cfg_ready = 1'b1;

	omtw_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: the input register moves on whenever the result register can load.
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (out_free || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			reading_s1 <= reading;
		end
	end

	omtw_tick_core #(
		.RETRY_LIMIT (RETRY_LIMIT)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.reading (reading_s1),
		.cfg     (cfg),
		.result  (res_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_next;
		end
	end

	assign out_valid          = out_valid_q;
	assign request_conversion = res_q.request_conversion;
	assign no_response        = res_q.no_response;
	assign temperature        = res_q.temperature;
	assign warning            = res_q.warning;
	assign error              = res_q.error;
	assign display_refresh    = res_q.display_refresh;

	// Checks on the tick logic and the handshake.
	`ASSERT_PROP(a_nores_is_sample, clk, arst_n, out_valid && no_response |-> request_conversion)
	`ASSERT_PROP(a_refresh_is_sample, clk, arst_n, out_valid && display_refresh |-> request_conversion)
	`ASSERT_PROP(a_error_needs_warn, clk, arst_n, out_valid && error |-> warning)
	`ASSERT_NEVER(a_stall_when_empty, clk, arst_n, in_stall && !(valid_s1 && out_valid_q))

endmodule

FILE: rtl/core/omtw_cfg_regs.sv
// Configuration register file of the over-temperature monitor.
`timescale 1ns / 1ps

module omtw_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [2:0]    wr_index,
	input  logic [15:0]   wr_data,
	output omtw_pkg::cfg_t cfg
);
	import omtw_pkg::*;

	cfg_t cfg_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warn_level        <= WARN_LEVEL_RST;
			cfg_q.trip_level        <= TRIP_LEVEL_RST;
			cfg_q.conversion_ticks  <= CONVERSION_TICKS_RST;
			cfg_q.trip_window_ticks <= TRIP_WINDOW_TICKS_RST;
			cfg_q.sensor_present    <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				CFG_WARN_LEVEL: begin
					cfg_q.warn_level <= wr_data[11:0];
				end
				CFG_TRIP_LEVEL: begin
					cfg_q.trip_level <= wr_data[11:0];
				end
				CFG_CONVERSION_TICKS: begin
					cfg_q.conversion_ticks <= wr_data;
				end
				CFG_TRIP_WINDOW_TICKS: begin
					cfg_q.trip_window_ticks <= wr_data;
				end
				CFG_SENSOR_PRESENT: begin
					cfg_q.sensor_present <= wr_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/omtw_tick_core.sv
// Per-tick state update: conversion timing, retries, thresholds and trip window.
`timescale 1ns / 1ps

module omtw_tick_core #(
	parameter int unsigned RETRY_LIMIT = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  omtw_pkg::temp_t   reading,
	input  omtw_pkg::cfg_t    cfg,
	output omtw_pkg::result_t result
);
	import omtw_pkg::*;

	localparam logic [1:0] RETRY_RST = 2'(RETRY_LIMIT);

	ticks_t     wait_q, wait_n;
	logic [1:0] retries_q, retries_n;
	temp_t      temp_q, temp_n;
	logic       warn_q, warn_n;
	logic       err_q, err_n;
	logic       armed_q, armed_n;
	ticks_t     wcount_q, wcount_n;
	logic       sample;
	logic       req;
	logic       nores;
	logic       refresh;

	// Next state for the tick held in the input register.
	always_comb begin
		wait_n    = wait_q;
		retries_n = retries_q;
		temp_n    = temp_q;
		warn_n    = warn_q;
		err_n     = err_q;
		armed_n   = armed_q;
		wcount_n  = wcount_q;
		sample    = 1'b0;
		req       = 1'b0;
		nores     = 1'b0;
		refresh   = 1'b0;
		if (cfg.sensor_present) begin
			// Conversion wait and retry handling.
			if (wait_q >= cfg.conversion_ticks) begin
				if (reading == NO_READING && retries_q != 2'd0) begin
					retries_n = retries_q - 2'd1;
					wait_n    = '0;
				end else begin
					if (reading == NO_READING) begin
						nores = 1'b1;
					end else begin
						temp_n = reading;
					end
					sample = 1'b1;
				end
			end else begin
				wait_n = wait_q + 16'd1;
			end

			// Threshold check on a completed sample.
			if (sample) begin
				retries_n = RETRY_RST;
				wait_n    = '0;
				req       = 1'b1;
				if (temp_n <= cfg.warn_level) begin
					warn_n   = 1'b0;
					refresh  = err_q;
					err_n    = 1'b0;
					armed_n  = 1'b0;
					wcount_n = '0;
				end else begin
					warn_n = 1'b1;
					if (temp_n > cfg.trip_level && !err_q) begin
						if (!armed_q) begin
							armed_n  = 1'b1;
							wcount_n = '0;
						end else if (wcount_q >= cfg.trip_window_ticks) begin
							err_n   = 1'b1;
							refresh = 1'b1;
						end
					end else if (temp_n <= cfg.trip_level && err_q) begin
						armed_n  = 1'b0;
						wcount_n = '0;
						err_n    = 1'b0;
						refresh  = 1'b1;
					end
				end
			end

			// Window count runs while armed and saturates.
			if (armed_q && armed_n && wcount_n != 16'hFFFF) begin
				wcount_n = wcount_n + 16'd1;
			end
		end
	end

	// State registers advance once per tick word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q    <= '0;
			retries_q <= RETRY_RST;
			temp_q    <= NO_READING;
			warn_q    <= 1'b0;
			err_q     <= 1'b0;
			armed_q   <= 1'b0;
			wcount_q  <= '0;
		end else if (step) begin
			wait_q    <= wait_n;
			retries_q <= retries_n;
			temp_q    <= temp_n;
			warn_q    <= warn_n;
			err_q     <= err_n;
			armed_q   <= armed_n;
			wcount_q  <= wcount_n;
		end
	end

	assign result.request_conversion = req;
	assign result.no_response        = nores;
	assign result.temperature        = temp_n;
	assign result.warning            = warn_n;
	assign result.error              = err_n;
	assign result.display_refresh    = refresh;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the over-temperature monitor with trip window.
`timescale 1ns / 1ps

module tb;
	import omtw_pkg::*;

	localparam logic [1:0] RETRY_LIMIT = 2'd3;

	// Kinds of rows in the directed script.
	typedef enum bit {ROW_TICK, ROW_CFG} row_kind_t;

	// One directed row: a tick word or a register write, with an optional literal result.
	typedef struct packed {
		row_kind_t          kind;
		logic [2:0]         idx;
		logic signed [31:0] value;
		bit                 fixed;
		result_t            word;
	} script_row_t;

	localparam int SCRIPT_LEN = 37;

	// Tick rows ignore the index field.
	script_row_t script [SCRIPT_LEN] = '{
		'{ROW_TICK, '0, 0, 1'b1, '{1'b0, 1'b0, NO_READING, 1'b0, 1'b0, 1'b0}},
		'{ROW_TICK, '0, 2047, 1'b1, '{1'b0, 1'b0, NO_READING, 1'b0, 1'b0, 1'b0}},
		'{ROW_TICK, '0, -2048, 1'b1, '{1'b0, 1'b0, NO_READING, 1'b0, 1'b0, 1'b0}},
		'{ROW_CFG, CFG_CONVERSION_TICKS, 0, 1'b0, '0},
		'{ROW_CFG, CFG_TRIP_WINDOW_TICKS, 0, 1'b0, '0},
		'{ROW_TICK, '0, -2048, 1'b1, '{1'b1, 1'b0, -12'sd2048, 1'b0, 1'b0, 1'b0}},
		'{ROW_TICK, '0, 2047, 1'b1, '{1'b1, 1'b0, 12'sd2047, 1'b1, 1'b0, 1'b0}},
		'{ROW_TICK, '0, 2047, 1'b1, '{1'b1, 1'b0, 12'sd2047, 1'b1, 1'b1, 1'b1}},
		'{ROW_TICK, '0, 1000, 1'b1, '{1'b1, 1'b0, 12'sd1000, 1'b1, 1'b0, 1'b1}},
		'{ROW_TICK, '0, NO_READING, 1'b1, '{1'b0, 1'b0, 12'sd1000, 1'b1, 1'b0, 1'b0}},
		'{ROW_TICK, '0, NO_READING, 1'b1, '{1'b0, 1'b0, 12'sd1000, 1'b1, 1'b0, 1'b0}},
		'{ROW_TICK, '0, NO_READING, 1'b1, '{1'b0, 1'b0, 12'sd1000, 1'b1, 1'b0, 1'b0}},
		'{ROW_TICK, '0, NO_READING, 1'b1, '{1'b1, 1'b1, 12'sd1000, 1'b1, 1'b0, 1'b0}},
		'{ROW_TICK, '0, 2047, 1'b1, '{1'b1, 1'b0, 12'sd2047, 1'b1, 1'b0, 1'b0}},
		'{ROW_TICK, '0, 500, 1'b1, '{1'b1, 1'b0, 12'sd500, 1'b0, 1'b0, 1'b0}},
		'{ROW_CFG, CFG_WARN_LEVEL, -2048, 1'b0, '0},
		'{ROW_CFG, CFG_TRIP_LEVEL, 2047, 1'b0, '0},
		'{ROW_TICK, '0, -2047, 1'b1, '{1'b1, 1'b0, -12'sd2047, 1'b1, 1'b0, 1'b0}},
		'{ROW_TICK, '0, 2047, 1'b1, '{1'b1, 1'b0, 12'sd2047, 1'b1, 1'b0, 1'b0}},
		'{ROW_CFG, CFG_WARN_LEVEL, 2047, 1'b0, '0},
		'{ROW_TICK, '0, 2047, 1'b1, '{1'b1, 1'b0, 12'sd2047, 1'b0, 1'b0, 1'b0}},
		'{ROW_CFG, CFG_SENSOR_PRESENT, 0, 1'b0, '0},
		'{ROW_TICK, '0, 100, 1'b1, '{1'b0, 1'b0, 12'sd2047, 1'b0, 1'b0, 1'b0}},
		'{ROW_CFG, CFG_SENSOR_PRESENT, 1, 1'b0, '0},
		'{ROW_CFG, CFG_CONVERSION_TICKS, 65535, 1'b0, '0},
		'{ROW_TICK, '0, 1, 1'b1, '{1'b0, 1'b0, 12'sd2047, 1'b0, 1'b0, 1'b0}},
		'{ROW_CFG, CFG_WARN_LEVEL, 960, 1'b0, '0},
		'{ROW_CFG, CFG_TRIP_LEVEL, 1280, 1'b0, '0},
		'{ROW_CFG, CFG_CONVERSION_TICKS, 1, 1'b0, '0},
		'{ROW_CFG, CFG_TRIP_WINDOW_TICKS, 3, 1'b0, '0},
		'{ROW_TICK, '0, 1400, 1'b0, '0},
		'{ROW_TICK, '0, 1100, 1'b0, '0},
		'{ROW_TICK, '0, 1400, 1'b0, '0},
		'{ROW_TICK, '0, 1400, 1'b0, '0},
		'{ROW_TICK, '0, 1400, 1'b0, '0},
		'{ROW_TICK, '0, 1400, 1'b0, '0},
		'{ROW_TICK, '0, 900, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	temp_t       reading = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        request_conversion;
	logic        no_response;
	temp_t       temperature;
	logic        warning;
	logic        error;
	logic        display_refresh;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Register copies and tick state of the predictor.
	temp_t      cfg_warn;
	temp_t      cfg_trip;
	ticks_t     cfg_conv;
	ticks_t     cfg_window;
	logic       cfg_present;
	ticks_t     wait_cnt;
	logic [1:0] tries_left;
	temp_t      held_temp;
	logic       warn_q;
	logic       err_q;
	logic       win_armed;
	ticks_t     win_cnt;

	result_t expected_status[$];

	int  failures = 0;
	int  ticks_sent = 0;
	int  results_seen = 0;
	int  trips_seen = 0;
	int  nores_seen = 0;
	int  settings_used = 0;
	int  burst_left = 0;
	bit  gaps_on = 1'b1;
	bit  cfg_open = 1'b0;
	int  walk = 0;
	int  no_reply_run = 0;
	int  stall_mode = 0;
	int  stall_left = 0;
	int  hold_run = 0;
	int  stall_cyc = 0;

	overtemp_monitor_with_trip_window #(
		.RETRY_LIMIT(RETRY_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.reading(reading),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.request_conversion(request_conversion),
		.no_response(no_response),
		.temperature(temperature),
		.warning(warning),
		.error(error),
		.display_refresh(display_refresh),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 250 MHz clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Advances the predicted monitor by one tick and returns the status word it shows.
	function automatic result_t next_status(temp_t r);
		result_t res;
		bit was_armed;
		bit take;
		res = '0;
		was_armed = win_armed;
		take = 1'b0;
		if (cfg_present) begin
			if (wait_cnt >= cfg_conv) begin
				if (r == NO_READING && tries_left != 0) begin
					tries_left--;
					wait_cnt = '0;
				end else begin
					if (r == NO_READING)
						res.no_response = 1'b1;
					else
						held_temp = r;
					take = 1'b1;
				end
			end else begin
				wait_cnt++;
			end

			// A completed sample requests a new conversion and checks the thresholds.
			if (take) begin
				tries_left = RETRY_LIMIT;
				wait_cnt = '0;
				res.request_conversion = 1'b1;
				if (held_temp <= cfg_warn) begin
					warn_q = 1'b0;
					res.display_refresh = err_q;
					err_q = 1'b0;
					win_armed = 1'b0;
					win_cnt = '0;
				end else begin
					warn_q = 1'b1;
					if (held_temp > cfg_trip && !err_q) begin
						if (!win_armed) begin
							win_armed = 1'b1;
							win_cnt = '0;
						end else if (win_cnt >= cfg_window) begin
							err_q = 1'b1;
							res.display_refresh = 1'b1;
						end
					end else if (held_temp <= cfg_trip && err_q) begin
						win_armed = 1'b0;
						win_cnt = '0;
						err_q = 1'b0;
						res.display_refresh = 1'b1;
					end
				end
			end

			// The window counter only runs on ticks after the one that armed it.
			if (was_armed && win_armed && win_cnt != '1)
				win_cnt++;
		end
		res.temperature = held_temp;
		res.warning = warn_q;
		res.error = err_q;
		return res;
	endfunction

	// Picks the next reading: a walk around the thresholds, no-response runs, and noise.
	function automatic temp_t pick_reading();
		int roll;
		if (no_reply_run != 0) begin
			no_reply_run--;
			return NO_READING;
		end
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			no_reply_run = $urandom_range(0, 4);
			return NO_READING;
		end
		if (roll < 16)
			return temp_t'($urandom);
		if (roll < 21)
			walk = int'(cfg_trip) + int'($urandom_range(0, 200)) - 100;
		else
			walk = walk + int'($urandom_range(0, 120)) - 60;
		if (walk > 2047)
			walk = 2047;
		if (walk < -2048)
			walk = -2048;
		return temp_t'(walk);
	endfunction

	// Offers one tick word, honoring the burst and gap pattern, and records its expectation.
	task automatic send_reading(temp_t r, bit fixed, result_t fixed_word);
		int gap;
		result_t predicted;
		if (cfg_open) begin
			cfg_valid <= 1'b0;
			cfg_open = 1'b0;
		end
		if (burst_left == 0) begin
			if (gaps_on) begin
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		reading <= r;
		do @(posedge clk); while (in_stall);
		predicted = next_status(r);
		expected_status.push_back(fixed ? fixed_word : predicted);
		ticks_sent++;
	endtask

	// Holds off the sender until every expected word has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_status.size() != 0)
			@(posedge clk);
	endtask

	// Writes one register; valid stays up between back-to-back writes.
	task automatic write_cfg(logic [2:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_WARN_LEVEL:        cfg_warn = data[11:0];
			CFG_TRIP_LEVEL:        cfg_trip = data[11:0];
			CFG_CONVERSION_TICKS:  cfg_conv = data;
			CFG_TRIP_WINDOW_TICKS: cfg_window = data;
			CFG_SENSOR_PRESENT:    cfg_present = data[0];
			default: ;
		endcase
		cfg_open = 1'b1;
	endtask

	task automatic cmp_field(string fname, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			failures++;
		end
	endtask

	// Receiver stall pattern: no stalls, random stalls, a fixed rhythm, or long holds.
	always @(posedge clk) begin : stall_pattern
		bit s;
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(50, 300);
		end else begin
			stall_left--;
		end
		stall_cyc++;
		case (stall_mode)
			0: s = 1'b0;
			1: s = ($urandom_range(0, 2) == 0);
			2: s = (stall_cyc % 4 == 3);
			default: begin
				if (hold_run == 0 && $urandom_range(0, 9) == 0)
					hold_run = $urandom_range(1, 8);
				s = (hold_run != 0);
				if (s)
					hold_run--;
			end
		endcase
		out_stall <= s;
	end

	// Each accepted result word is checked against the oldest expectation.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_status.size() == 0) begin
				$error("result word arrived with no tick waiting for it");
				failures++;
			end else begin
				want = expected_status.pop_front();
				cmp_field("request_conversion", want.request_conversion, request_conversion);
				cmp_field("no_response", want.no_response, no_response);
				cmp_field("temperature", want.temperature, temperature);
				cmp_field("warning", want.warning, warning);
				cmp_field("error", want.error, error);
				cmp_field("display_refresh", want.display_refresh, display_refresh);
				results_seen++;
				if (error && display_refresh)
					trips_seen++;
				if (no_response)
					nores_seen++;
			end
		end
	end

	// Stimulus: reset, the directed script, then random phases.
	initial begin
		int w;
		int t;
		cfg_warn = WARN_LEVEL_RST;
		cfg_trip = TRIP_LEVEL_RST;
		cfg_conv = CONVERSION_TICKS_RST;
		cfg_window = TRIP_WINDOW_TICKS_RST;
		cfg_present = 1'b1;
		wait_cnt = '0;
		tries_left = RETRY_LIMIT;
		held_temp = NO_READING;
		warn_q = 1'b0;
		err_q = 1'b0;
		win_armed = 1'b0;
		win_cnt = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script.
		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				wait_idle();
				write_cfg(script[i].idx, script[i].value[15:0]);
			end else begin
				send_reading(script[i].value[11:0], script[i].fixed, script[i].word);
			end
		end

		// Random phases, each under its own register setting.
		for (int phase = 0; phase < 7; phase++) begin
			wait_idle();
			case ($urandom_range(0, 5))
				0: w = -2048;
				1: w = 2047;
				default: w = int'($urandom_range(0, 1600)) - 200;
			endcase
			case ($urandom_range(0, 5))
				0: t = 2047;
				1: t = w - int'($urandom_range(0, 300));
				default: t = w + int'($urandom_range(0, 400));
			endcase
			if (t > 2047)
				t = 2047;
			if (t < -2048)
				t = -2048;
			write_cfg(CFG_WARN_LEVEL, 16'(w));
			write_cfg(CFG_TRIP_LEVEL, 16'(t));
			case ($urandom_range(0, 5))
				0: write_cfg(CFG_CONVERSION_TICKS, 16'd0);
				1: write_cfg(CFG_CONVERSION_TICKS, 16'($urandom_range(10, 40)));
				default: write_cfg(CFG_CONVERSION_TICKS, 16'($urandom_range(1, 4)));
			endcase
			case ($urandom_range(0, 5))
				0: write_cfg(CFG_TRIP_WINDOW_TICKS, 16'd0);
				1: write_cfg(CFG_TRIP_WINDOW_TICKS, 16'hFFFF);
				default: write_cfg(CFG_TRIP_WINDOW_TICKS, 16'($urandom_range(1, 30)));
			endcase
			write_cfg(CFG_SENSOR_PRESENT, 16'($urandom_range(0, 7) != 0));
			settings_used++;
			walk = int'(cfg_warn);
			gaps_on = (phase % 3 != 1);
			repeat (75)
				send_reading(pick_reading(), 1'b0, '0);
		end

		// Let the last words drain, then allow for any stray output.
		if (cfg_open) begin
			cfg_valid <= 1'b0;
			cfg_open = 1'b0;
		end
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Checked %0d result words from %0d ticks under %0d random settings.",
			results_seen, ticks_sent, settings_used);
		$display("Saw %0d error latches and %0d exhausted-retry samples.",
			trips_seen, nores_seen);
		if (failures == 0 && expected_status.size() == 0) begin
			$display("overtemp_monitor_with_trip_window: match");
		end else begin
			$display("overtemp_monitor_with_trip_window: mismatch");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(4_000_000);
		$display("overtemp_monitor_with_trip_window: mismatch");
		$finish;
	end

endmodule
